>>> rtl/mpfc_pkg.sv
// Package: types, codes and constants of the music play and fade controller.
`timescale 1ns / 1ps
package mpfc_pkg;

  localparam logic [4:0] ST_STOPPED = 5'd1;
  localparam logic [4:0] ST_PLAYING = 5'd2;
  localparam logic [4:0] ST_PAUSED  = 5'd4;
  localparam logic [4:0] ST_FADEOUT = 5'd8;
  localparam logic [4:0] ST_FADING  = 5'd16;

  localparam logic [3:0] CMD_START     = 4'd1;
  localparam logic [3:0] CMD_START_CHG = 4'd2;
  localparam logic [3:0] CMD_STOP      = 4'd3;
  localparam logic [3:0] CMD_CONTINUE  = 4'd4;
  localparam logic [3:0] CMD_VOLUME    = 4'd5;
  localparam logic [3:0] CMD_FADE_OUT  = 4'd6;
  localparam logic [3:0] CMD_FADE_IN   = 4'd7;
  localparam logic [3:0] CMD_INIT      = 4'd8;

  localparam logic [2:0] REQ_PLAY    = 3'd0;
  localparam logic [2:0] REQ_PAUSE   = 3'd1;
  localparam logic [2:0] REQ_STOP    = 3'd2;
  localparam logic [2:0] REQ_UNPAUSE = 3'd3;
  localparam logic [2:0] REQ_FADEOUT = 3'd4;
  localparam logic [2:0] REQ_FADEIN  = 3'd5;
  localparam logic [2:0] REQ_SETVOL  = 3'd6;
  localparam logic [2:0] REQ_TICK    = 3'd7;

  localparam logic [15:0] FULL_X10   = 16'd2560;
  localparam logic [15:0] MIN_X10    = 16'd40;
  localparam logic [11:0] VOL_MASK   = 12'h1FC;
  localparam logic [7:0]  SONG_NONE  = 8'd255;
  localparam logic [7:0]  SONG_RESET = 8'd254;
  localparam int          DIV_BITS   = 16;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_FIX, S_OUT
  } state_e;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [7:0]  song;
    logic [11:0] value;
  } cmd_t;

  // Controller to datapath commands
  typedef struct packed {
    logic eval;     // evaluate accepted request
    logic div_step; // one restoring division step
    logic fix;      // apply quotient
    logic pop;      // drop head command
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic has_cmd;
  } sts_t;

endpackage

>>> rtl/mpfc_datapath.sv
// Datapath: status and volume registers, serial divider and command queue.
`timescale 1ns / 1ps
module mpfc_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            music_disabled_i,
  input  logic [2:0]      req_type_i,
  input  logic [7:0]      song_i,
  input  logic [15:0]     fade_time_i,
  input  logic [15:0]     level_i,
  input  logic            player_paused_i,
  input  mpfc_pkg::ctl_t  ctl_i,
  output mpfc_pkg::sts_t  sts_o,
  output logic [3:0]      command_o,
  output logic [7:0]      command_song_o,
  output logic [11:0]     command_value_o,
  output logic [4:0]      status_bits_o,
  output logic            last_o
);
  import mpfc_pkg::*;

  logic [4:0]  status_q, status_d;
  logic [7:0]  song_q, song_d;
  logic [15:0] vol_q, vol_d, tgt_q, tgt_d, step_q, step_d;
  cmd_t        buf_q [3];
  cmd_t        buf_d [3];
  logic [1:0]  cnt_q, cnt_d;
  // divider: request and signed mode flags
  logic        need_div, div_sgn, div_neg;
  logic [15:0] dvd_abs;
  logic        dsgn_q, dneg_q;
  logic [15:0] quo_q, den_q;
  logic [15:0] rem_q;
  logic [4:0]  dcnt_q;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  logic [15:0] qfix;
  logic [16:0] vsum;
  logic [15:0] lv;

  // volume over ten by reciprocal with one correction
  function automatic logic [15:0] vq10_after(input logic [15:0] v);
    logic [31:0] m;
    logic [15:0] r;
    m = 32'(v) * 32'd6554;
    r = m[31:16];
    if (32'(r) * 32'd10 > 32'(v)) r = r - 16'd1;
    return r;
  endfunction

  // evaluate one request into next state and queued commands
  always_comb begin
    logic [4:0]  st;
    logic        pend;
    logic [15:0] diff;
    cmd_t        q [3];
    logic [1:0]  n;
    st = status_q;
    song_d = song_q;
    vol_d = vol_q;
    tgt_d = tgt_q;
    step_d = step_q;
    need_div = 1'b0;
    div_sgn = 1'b0;
    div_neg = 1'b0;
    dvd_abs = '0;
    pend = 1'b0;
    diff = '0;
    n = 2'd0;
    for (int k = 0; k < 3; k++) q[k] = '0;
    lv = (level_i > 16'd256) ? 16'd256 : ((level_i < 16'd4) ? 16'd4 : level_i);
    vsum = {vol_q[15], vol_q} + {step_q[15], step_q};
    if (ctl_i.eval) begin
      unique case (req_type_i)
        REQ_PLAY: begin
          if (!music_disabled_i) begin
            q[0] = '{(st & ST_FADEOUT) != 0 ? CMD_START : CMD_START_CHG, song_i, 12'd0};
            n = 2'd1;
            song_d = song_i;
            vol_d = FULL_X10;
            st = ST_PLAYING;
          end
        end
        REQ_PAUSE: begin
          if ((st & ST_PLAYING) != 0) begin
            q[0] = '{CMD_STOP, 8'd0, 12'd0};
            n = 2'd1;
            st = (st & ~ST_PLAYING) | ST_PAUSED;
            if ((st & ST_FADEOUT) != 0) begin
              st = st | ST_STOPPED;
              q[1] = '{CMD_VOLUME, 8'd0, 12'd4};
              n = 2'd2;
            end
          end else st = st | ST_STOPPED;
        end
        REQ_STOP: begin
          if ((st & ST_STOPPED) == 0) begin
            q[0] = '{CMD_STOP, 8'd0, 12'd0};
            n = 2'd1;
            st = ST_STOPPED;
            song_d = SONG_NONE;
          end
        end
        REQ_UNPAUSE: begin
          if ((st & ST_PAUSED) != 0) begin
            if ((st & ST_STOPPED) == 0) begin
              q[0] = '{CMD_CONTINUE, 8'd0, 12'd0};
              n = 2'd1;
              st = (st & ~ST_PAUSED) | ST_PLAYING;
            end else st = st & ~ST_STOPPED;
          end
        end
        REQ_FADEOUT: begin
          if ((st & ST_PLAYING) != 0) begin
            q[0] = '{CMD_FADE_OUT, 8'd0, fade_time_i[15:4]};
            n = 2'd1;
            st = ST_FADEOUT | ST_PLAYING;
          end
        end
        REQ_FADEIN: begin
          if (!music_disabled_i) begin
            if (song_q == song_i && (st & ST_STOPPED) != 0) begin
              if ((st & ST_PAUSED) != 0) begin
                st = st & ~(ST_FADEOUT | ST_STOPPED);
                q[0] = '{CMD_START, song_i, 12'd0};
                q[1] = '{CMD_INIT, 8'd0, 12'd0};
                q[2] = '{CMD_STOP, 8'd0, 12'd0};
                n = 2'd3;
              end
            end else if (song_i == SONG_NONE) begin
              if ((st & ST_STOPPED) != 0) begin
                if ((st & ST_PAUSED) != 0) begin
                  st = st & ~ST_STOPPED;
                  // nested unpause: paused set, stopped now clear
                  if ((st & ST_FADEOUT) != 0) begin
                    q[0] = '{CMD_CONTINUE, 8'd0, 12'd0};
                    n = 2'd1;
                    st = (st & ~ST_PAUSED) | ST_PLAYING;
                  end
                end
              end else if ((st & ST_FADEOUT) != 0) begin
                q[0] = '{CMD_FADE_IN, 8'd0, fade_time_i[15:4]};
                n = 2'd1;
                st = ST_PLAYING;
              end else begin
                if ((st & ST_PAUSED) != 0) begin
                  q[0] = '{CMD_CONTINUE, 8'd0, 12'd0};
                  n = 2'd1;
                  st = (st & ~ST_PAUSED) | ST_PLAYING;
                end
                pend = 1'b1;
              end
            end else begin
              q[0] = '{(st & ST_FADEOUT) != 0 ? CMD_START : CMD_START_CHG, song_i, 12'd0};
              q[1] = '{CMD_INIT, 8'd0, 12'd0};
              n = 2'd2;
              song_d = song_i;
              vol_d = FULL_X10;
              st = ST_PLAYING;
              pend = 1'b1;
            end
            if (pend && fade_time_i != 16'd0) begin
              need_div = 1'b1;
              dvd_abs = tgt_q;
              st = ST_FADING | ST_PLAYING;
              vol_d = MIN_X10;
            end
          end
        end
        REQ_SETVOL: begin
          if ((st & (ST_STOPPED | ST_PAUSED)) == 0) begin
            if (fade_time_i != 16'd0) begin
              tgt_d = 16'(lv * 16'd10);
              diff = tgt_d - vol_q;
              need_div = 1'b1;
              div_sgn = 1'b1;
              div_neg = diff[15];
              dvd_abs = diff[15] ? -diff : diff;
              st = st | ST_FADING;
            end else begin
              q[0] = '{CMD_VOLUME, 8'd0, 12'(lv) & VOL_MASK};
              n = 2'd1;
              vol_d = 16'(lv * 16'd10);
            end
          end
        end
        default: begin
          if ((st & (ST_STOPPED | ST_PAUSED)) == 0) begin
            if (step_q != 16'd0) begin
              vol_d = vsum[15:0];
              if ((!step_q[15] && $signed(vsum[15:0]) > $signed(tgt_q)) ||
                  (step_q[15] && $signed(vsum[15:0]) < $signed(tgt_q))) begin
                vol_d = tgt_q;
                step_d = '0;
                st = ST_PLAYING;
              end
              q[0] = '{CMD_VOLUME, 8'd0, 12'(vq10_after(vol_d)) & VOL_MASK};
              n = 2'd1;
            end else if (player_paused_i) st = ST_PAUSED;
          end
        end
      endcase
    end
    status_d = st;
    for (int k = 0; k < 3; k++) buf_d[k] = q[k];
    cnt_d = n;
  end

  // one divide step per cycle
  assign rem_sh  = {rem_q, quo_q[15]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign qfix = dsgn_q ? (dneg_q ? -quo_q : quo_q) : quo_q + 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= ST_STOPPED;
      song_q <= SONG_RESET;
      vol_q <= FULL_X10;
      tgt_q <= FULL_X10;
      step_q <= '0;
      cnt_q <= '0;
      dcnt_q <= '0;
    end else if (ctl_i.eval) begin
      status_q <= status_d;
      song_q <= song_d;
      vol_q <= vol_d;
      tgt_q <= tgt_d;
      step_q <= step_d;
      buf_q <= buf_d;
      cnt_q <= cnt_d;
      dsgn_q <= div_sgn;
      dneg_q <= div_neg;
      quo_q <= dvd_abs;
      den_q <= fade_time_i;
      rem_q <= '0;
      dcnt_q <= 5'(DIV_BITS);
    end else if (ctl_i.div_step) begin
      if (!rem_sub[16]) begin
        rem_q <= rem_sub[15:0];
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        rem_q <= rem_sh[15:0];
        quo_q <= {quo_q[14:0], 1'b0};
      end
      dcnt_q <= dcnt_q - 5'd1;
    end else if (ctl_i.fix) begin
      step_q <= qfix;
    end else if (ctl_i.pop) begin
      buf_q[0] <= buf_q[1];
      buf_q[1] <= buf_q[2];
      cnt_q <= cnt_q - 2'd1;
    end
  end

  assign sts_o = '{need_div: need_div, div_done: (dcnt_q == 5'd0), has_cmd: (cnt_q != 2'd0)};
  assign command_o       = buf_q[0].cmd;
  assign command_song_o  = buf_q[0].song;
  assign command_value_o = buf_q[0].value;
  assign status_bits_o   = status_q;
  assign last_o          = (cnt_q == 2'd1);
endmodule

>>> rtl/mpfc_ctrl.sv
// Controller: sequences evaluation, division and command delivery.
`timescale 1ns / 1ps
module mpfc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  mpfc_pkg::sts_t sts_i,
  output mpfc_pkg::ctl_t ctl_o
);
  import mpfc_pkg::*;

  state_e state_q, state_d;

  // hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  // advance on request, divide and fix the step when needed, then drain commands
  always_comb begin
    state_d = state_q;
    ctl_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.eval = 1'b1;
          state_d = sts_i.need_div ? S_DIV : S_OUT;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_FIX;
        else ctl_o.div_step = 1'b1;
      end
      S_FIX: begin
        ctl_o.fix = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!sts_i.has_cmd) state_d = S_IDLE;
        else begin
          out_valid_o = 1'b1;
          if (out_ready_i) ctl_o.pop = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

>>> rtl/music_play_fade_controller.sv
// Top level: music play and fade controller.
// A request is evaluated when accepted; a fade-in or volume fade then runs
// the one-bit-per-cycle restoring divider for the fade step. No new request
// is taken until every command of the last one has been delivered.
// Reset: asynchronous active low; stopped, song 254, volume and target 2560.
`timescale 1ns / 1ps
module music_play_fade_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic [7:0]  song_i,
  input  logic [15:0] fade_time_i,
  input  logic [15:0] level_i,
  input  logic        player_paused_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  command_o,
  output logic [7:0]  command_song_o,
  output logic [11:0] command_value_o,
  output logic [4:0]  status_bits_o,
  output logic        last_o
);
  import mpfc_pkg::*;

  logic dis_q;
  ctl_t ctl;
  sts_t sts;

  // hold configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dis_q <= 1'b0;
    else if (cfg_we_i) dis_q <= cfg_wdata_i;
  end

  mpfc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .out_valid_o, .out_ready_i, .sts_i(sts), .ctl_o(ctl)
  );

  mpfc_datapath u_dp (
    .clk_i, .rst_ni, .music_disabled_i(dis_q), .req_type_i, .song_i, .fade_time_i,
    .level_i, .player_paused_i, .ctl_i(ctl), .sts_o(sts), .command_o,
    .command_song_o, .command_value_o, .status_bits_o, .last_o
  );

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("accept while delivering");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |=> !out_valid_o)
    else $error("command after last");
endmodule

>>> bench/tb_top.sv
// Testbench: random and directed requests checked against a built-in player model.
`timescale 1ns / 1ps
module tb_top;
  import mpfc_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  song;
    logic [15:0] fade_time;
    logic [15:0] level;
    logic        ext_paused;
  } request_t;

  typedef struct {
    logic [3:0]  cmd;
    logic [7:0]  song;
    logic [11:0] value;
    logic [4:0]  status;
    logic        last;
  } player_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  req_type_i = '0;
  logic [7:0]  song_i = '0;
  logic [15:0] fade_time_i = '0;
  logic [15:0] level_i = '0;
  logic        player_paused_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  command_o;
  logic [7:0]  command_song_o;
  logic [11:0] command_value_o;
  logic [4:0]  status_bits_o;
  logic        last_o;

  music_play_fade_controller u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .req_type_i, .song_i, .fade_time_i, .level_i, .player_paused_i,
    .out_valid_o, .out_ready_i, .command_o, .command_song_o,
    .command_value_o, .status_bits_o, .last_o
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  request_t    pending_reqs[$];
  player_cmd_t expected_cmds[$];
  int          mismatches = 0;
  int          cmds_seen = 0;
  int          reqs_sent = 0;
  int          cycles = 0;
  bit          no_idle = 0;

  // Player model state
  logic        mdl_disabled = 1'b0;
  logic [4:0]  mdl_status = ST_STOPPED;
  logic [7:0]  mdl_song = SONG_RESET;
  int          mdl_volume = 2560;
  int          mdl_target = 2560;
  int          mdl_step = 0;
  player_cmd_t new_cmds[$];

  function automatic void add_cmd(logic [3:0] c, logic [7:0] s, logic [11:0] v);
    player_cmd_t pc;
    pc.cmd = c; pc.song = s; pc.value = v; pc.status = '0; pc.last = 1'b0;
    if (new_cmds.size() < 3) new_cmds.push_back(pc);
  endfunction

  function automatic void model_play(logic [7:0] s);
    add_cmd((mdl_status & ST_FADEOUT) != 0 ? CMD_START : CMD_START_CHG, s, '0);
    mdl_song = s;
    mdl_volume = 2560;
    mdl_status = ST_PLAYING;
  endfunction

  function automatic void model_unpause();
    if ((mdl_status & ST_PAUSED) != 0) begin
      if ((mdl_status & ST_STOPPED) == 0) begin
        add_cmd(CMD_CONTINUE, '0, '0);
        mdl_status = (mdl_status & ~ST_PAUSED) | ST_PLAYING;
      end else begin
        mdl_status = mdl_status & ~ST_STOPPED;
      end
    end
  endfunction

  function automatic void model_fade_in(logic [7:0] s, logic [15:0] ft);
    if (mdl_disabled) return;
    if (mdl_song == s && (mdl_status & ST_STOPPED) != 0) begin
      if ((mdl_status & ST_PAUSED) != 0) begin
        mdl_status = mdl_status & ~(ST_FADEOUT | ST_STOPPED);
        add_cmd(CMD_START, s, '0);
        add_cmd(CMD_INIT, '0, '0);
        add_cmd(CMD_STOP, '0, '0);
      end
      return;
    end
    if (s == SONG_NONE) begin
      if ((mdl_status & ST_STOPPED) != 0) begin
        if ((mdl_status & ST_PAUSED) != 0) begin
          mdl_status = mdl_status & ~ST_STOPPED;
          if ((mdl_status & ST_FADEOUT) != 0) model_unpause();
        end
        return;
      end
      if ((mdl_status & ST_FADEOUT) != 0) begin
        add_cmd(CMD_FADE_IN, '0, 12'(ft / 16));
        mdl_status = ST_PLAYING;
        return;
      end
      model_unpause();
    end else begin
      model_play(s);
      add_cmd(CMD_INIT, '0, '0);
    end
    if (ft == 0) return;
    mdl_step = mdl_target / int'(ft) + 1;
    mdl_status = ST_FADING | ST_PLAYING;
    mdl_volume = 40;
  endfunction

  function automatic void model_set_volume(logic [15:0] lvl, logic [15:0] ft);
    int v;
    v = int'(lvl);
    if ((mdl_status & (ST_STOPPED | ST_PAUSED)) != 0) return;
    if (v > 256) v = 256;
    else if (v < 4) v = 4;
    if (ft != 0) begin
      mdl_target = v * 10;
      mdl_step = (mdl_target - mdl_volume) / int'(ft);
      mdl_status = mdl_status | ST_FADING;
    end else begin
      add_cmd(CMD_VOLUME, '0, 12'(v) & VOL_MASK);
      mdl_volume = v * 10;
    end
  endfunction

  function automatic void model_tick(logic ext_paused);
    if ((mdl_status & (ST_STOPPED | ST_PAUSED)) != 0) return;
    if (mdl_step != 0) begin
      mdl_volume = mdl_volume + mdl_step;
      if ((mdl_step > 0 && mdl_volume > mdl_target) ||
          (mdl_step < 0 && mdl_volume < mdl_target)) begin
        mdl_volume = mdl_target;
        mdl_step = 0;
        mdl_status = ST_PLAYING;
      end
      add_cmd(CMD_VOLUME, '0, 12'(mdl_volume / 10) & VOL_MASK);
    end else if (ext_paused) begin
      mdl_status = ST_PAUSED;
    end
  endfunction

  // Advance the model by one request and queue the commands it causes
  function automatic void predict_commands(request_t r);
    new_cmds.delete();
    case (r.kind)
      REQ_PLAY: if (!mdl_disabled) model_play(r.song);
      REQ_PAUSE: begin
        if ((mdl_status & ST_PLAYING) != 0) begin
          add_cmd(CMD_STOP, '0, '0);
          mdl_status = (mdl_status & ~ST_PLAYING) | ST_PAUSED;
          if ((mdl_status & ST_FADEOUT) != 0) begin
            mdl_status = mdl_status | ST_STOPPED;
            add_cmd(CMD_VOLUME, '0, 12'd4);
          end
        end else begin
          mdl_status = mdl_status | ST_STOPPED;
        end
      end
      REQ_STOP: begin
        if ((mdl_status & ST_STOPPED) == 0) begin
          add_cmd(CMD_STOP, '0, '0);
          mdl_status = ST_STOPPED;
          mdl_song = SONG_NONE;
        end
      end
      REQ_UNPAUSE: model_unpause();
      REQ_FADEOUT: begin
        if ((mdl_status & ST_PLAYING) != 0) begin
          add_cmd(CMD_FADE_OUT, '0, 12'(r.fade_time / 16));
          mdl_status = ST_FADEOUT | ST_PLAYING;
        end
      end
      REQ_FADEIN: model_fade_in(r.song, r.fade_time);
      REQ_SETVOL: model_set_volume(r.level, r.fade_time);
      default: model_tick(r.ext_paused);
    endcase
    foreach (new_cmds[k]) begin
      new_cmds[k].status = mdl_status;
      new_cmds[k].last = (k == new_cmds.size() - 1);
      expected_cmds.push_back(new_cmds[k]);
    end
  endfunction

  // Driver: present requests from the pending queue with random gaps
  int sender_gap = 0;
  always @(posedge clk_i) begin
    logic     hold;
    request_t r;
    hold = in_valid_i;
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_commands('{req_type_i, song_i, fade_time_i, level_i, player_paused_i});
      reqs_sent++;
      hold = 1'b0;
      sender_gap = no_idle ? 0 : $urandom_range(0, 11);
    end
    if (rst_ni && !hold) begin
      if (sender_gap > 0) begin
        sender_gap--;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs.pop_front();
        req_type_i <= r.kind;
        song_i <= r.song;
        fade_time_i <= r.fade_time;
        level_i <= r.level;
        player_paused_i <= r.ext_paused;
        hold = 1'b1;
      end
    end
    in_valid_i <= hold;
  end

  // Monitor: accept commands with random stalls and compare with the model
  int receiver_stall = 0;
  always @(posedge clk_i) begin
    player_cmd_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      cmds_seen++;
      receiver_stall = no_idle ? 0 : $urandom_range(0, 11);
      if (expected_cmds.size() == 0) begin
        $error("unexpected command %0d", command_o);
        mismatches++;
      end else begin
        e = expected_cmds.pop_front();
        if (command_o !== e.cmd) begin
          $error("command: expected %0d, got %0d", e.cmd, command_o); mismatches++;
        end
        if (command_song_o !== e.song) begin
          $error("command_song: expected %0d, got %0d", e.song, command_song_o);
          mismatches++;
        end
        if (command_value_o !== e.value) begin
          $error("command_value: expected %0d, got %0d", e.value, command_value_o);
          mismatches++;
        end
        if (status_bits_o !== e.status) begin
          $error("status_bits: expected %0h, got %0h", e.status, status_bits_o);
          mismatches++;
        end
        if (last_o !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, last_o); mismatches++;
        end
      end
    end
    if (receiver_stall > 0) begin
      receiver_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni;
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 300000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_req(logic [2:0] k, logic [7:0] s, logic [15:0] ft,
                          logic [15:0] lv, logic pp);
    request_t r;
    r.kind = k; r.song = s; r.fade_time = ft; r.level = lv; r.ext_paused = pp;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [7:0] pick_song();
    int p;
    p = $urandom_range(0, 9);
    if (p < 5) return 8'($urandom_range(0, 3));
    if (p < 7) return SONG_NONE;
    if (p < 8) return SONG_RESET;
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] pick_fade();
    int p;
    p = $urandom_range(0, 19);
    if (p < 6) return '0;
    if (p < 18) return 16'($urandom_range(1, 8));
    return 16'($urandom);
  endfunction

  // Mostly well-formed player traffic, with some fully random requests
  task automatic push_random(int n);
    int p;
    repeat (n) begin
      p = $urandom_range(0, 99);
      if (p < 35)
        push_req(REQ_TICK, 8'($urandom), 16'($urandom), 16'($urandom),
                 $urandom_range(0, 7) == 0);
      else if (p < 50)
        push_req(REQ_SETVOL, 8'($urandom), pick_fade(),
                 $urandom_range(0, 3) == 0 ? 16'($urandom)
                                           : 16'($urandom_range(0, 300)), 1'($urandom));
      else if (p < 60)
        push_req(REQ_FADEIN, pick_song(), pick_fade(), 16'($urandom), 1'($urandom));
      else if (p < 68)
        push_req(REQ_PLAY, pick_song(), 16'($urandom), 16'($urandom), 1'($urandom));
      else if (p < 75)
        push_req(REQ_PAUSE, 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
      else if (p < 82)
        push_req(REQ_UNPAUSE, 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
      else if (p < 88)
        push_req(REQ_FADEOUT, 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
      else if (p < 93)
        push_req(REQ_STOP, 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
      else
        push_req(3'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  // Hold until the block is idle, then write the register
  task automatic write_disable(logic v);
    wait (pending_reqs.size() == 0 && !in_valid_i && expected_cmds.size() == 0);
    repeat (30) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mdl_disabled = v;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_disable(1'b0);

    // Directed: extremes and each corner of the player flow
    push_req(REQ_PLAY, 8'd0, 16'd0, 16'd0, 1'b0);
    push_req(REQ_SETVOL, 8'd0, 16'd0, 16'd0, 1'b0);
    push_req(REQ_SETVOL, 8'd0, 16'd0, 16'hFFFF, 1'b0);
    push_req(REQ_SETVOL, 8'd0, 16'd3, 16'd100, 1'b0);
    push_req(REQ_SETVOL, 8'd0, 16'd0, 16'd200, 1'b0);
    repeat (4) push_req(REQ_TICK, 8'd0, 16'd0, 16'd0, 1'b0);
    push_req(REQ_PAUSE, 8'd0, 16'd0, 16'd0, 1'b0);
    push_req(REQ_PAUSE, 8'd0, 16'd0, 16'd0, 1'b0);
    push_req(REQ_UNPAUSE, 8'd0, 16'd0, 16'd0, 1'b0);
    push_req(REQ_UNPAUSE, 8'd0, 16'd0, 16'd0, 1'b0);
    push_req(REQ_PLAY, 8'd3, 16'd0, 16'd0, 1'b0);
    push_req(REQ_FADEOUT, 8'd0, 16'hFFFF, 16'd0, 1'b0);
    push_req(REQ_PAUSE, 8'd0, 16'd0, 16'd0, 1'b0);
    push_req(REQ_FADEIN, 8'd3, 16'd0, 16'd0, 1'b0);
    push_req(REQ_FADEOUT, 8'd0, 16'd32, 16'd0, 1'b0);
    push_req(REQ_FADEIN, SONG_NONE, 16'd16, 16'd0, 1'b0);
    push_req(REQ_STOP, 8'd0, 16'd0, 16'd0, 1'b0);
    push_req(REQ_STOP, 8'd0, 16'd0, 16'd0, 1'b0);
    push_req(REQ_FADEIN, 8'd255, 16'd0, 16'd0, 1'b1);
    push_req(REQ_FADEIN, 8'd7, 16'd5, 16'd0, 1'b0);
    repeat (6) push_req(REQ_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1);
    push_req(REQ_TICK, 8'd0, 16'd0, 16'd0, 1'b1);
    push_random(110);

    write_disable(1'b1);
    push_random(60);
    write_disable(1'b0);
    no_idle = 1;
    push_random(50);
    wait (pending_reqs.size() == 0);
    no_idle = 0;
    push_random(60);
    write_disable(1'b1);
    push_random(40);

    // Drain
    wait (pending_reqs.size() == 0 && !in_valid_i && expected_cmds.size() == 0);
    repeat (30) @(posedge clk_i);
    if (expected_cmds.size() != 0) begin
      $error("%0d commands never arrived", expected_cmds.size());
      mismatches++;
    end
    $display("Sent %0d requests over four register settings; checked %0d commands.",
             reqs_sent, cmds_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
